[rtl/core/htwd_pkg.sv]
// ----------------------------------------------------------------------------
// htwd_pkg
// Shared types and codes of the tree-walk Huffman decoder: node entry layout,
// input mode codes and the node memory request.
// ----------------------------------------------------------------------------
package htwd_pkg;

  localparam int unsigned NodeIdxW = 10;
  localparam int unsigned SymW     = 8;

  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_DECODE  = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  // 30-bit node entry, symbol in the top byte, left child in the low bits
  typedef struct packed {
    logic [SymW-1:0]     symbol;
    logic                is_end;
    logic                leaf;
    logic [NodeIdxW-1:0] right;
    logic [NodeIdxW-1:0] left;
  } node_t;

  typedef struct packed {
    logic                wr_en;
    logic [NodeIdxW-1:0] wr_addr;
    node_t               wr_data;
    logic [NodeIdxW-1:0] rd_a_addr;
    logic [NodeIdxW-1:0] rd_b_addr;
  } mem_req_t;

endpackage

[rtl/core/htwd_if.sv]
// ----------------------------------------------------------------------------
// htwd channel interfaces
// Valid/ready channels of the decoder: input items, decoded results and the
// root register write port.
// ----------------------------------------------------------------------------
interface htwd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [9:0] node_index;
  logic [9:0] left_child;
  logic [9:0] right_child;
  logic       leaf_flag;
  logic       end_flag;
  logic [7:0] leaf_symbol;
  logic [7:0] data_byte;

  modport source (
    output valid, mode, node_index, left_child, right_child, leaf_flag,
           end_flag, leaf_symbol, data_byte,
    input  ready
  );
  modport sink (
    input  valid, mode, node_index, left_child, right_child, leaf_flag,
           end_flag, leaf_symbol, data_byte,
    output ready
  );
endinterface

interface htwd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_symbol;
  logic       stream_end;
  logic       last;

  modport source (output valid, out_symbol, stream_end, last, input ready);
  modport sink (input valid, out_symbol, stream_end, last, output ready);
endinterface

interface htwd_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] root_node;

  modport source (output valid, root_node, input ready);
  modport sink (input valid, root_node, output ready);
endinterface

[rtl/core/huffman_tree_walk_decoder_core.sv]
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_core
// Bit-serial Huffman decoder walking a node table held in a two-read-port
// memory; table load, restart and decode all arrive on the input channel.
// ----------------------------------------------------------------------------
// channel  dir  payload                                   transaction
// cfg_i    in   root_node                                 valid & ready
// in_i     in   mode, node_index, children, flags, data   valid & ready
// out_o    out  out_symbol, stream_end, last              valid & ready
//
// write and restart items are done when accepted; a decode item makes one
// fetch of the node where the walk stands, then one dependent node read per
// bit, and a flush step when it yields results; a stalled output can hold the
// walk and the flush; the end leaf stops the walk at its bit.
// port b keeps the root entry on hand so a return to the root costs nothing.
// one item is in flight at a time; in_i.ready is high only when idle and no
// root write is offered; cfg_i.ready is high only when idle.
// rst_ni clears the walk to node 0 with the table left unwritten.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder_core import htwd_pkg::*; #(
  parameter int unsigned NODE_COUNT = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  htwd_cfg_if.sink   cfg_i,
  htwd_in_if.sink    in_i,
  htwd_out_if.source out_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [NodeIdxW-1:0] root_q, root_d;
  logic [NodeIdxW-1:0] walk_q, walk_d;
  logic                finished_q, finished_d;
  logic                pend_valid_q, pend_valid_d;
  logic                out_valid_q, out_valid_d;
  logic [2:0]          cnt_q, cnt_d;
  logic [7:0]          byte_q, byte_d;
  logic [NodeIdxW-1:0] rd_addr_q, rd_addr_d;
  logic [SymW-1:0]     pend_sym_q, pend_sym_d;
  logic                pend_end_q, pend_end_d;
  logic [SymW-1:0]     out_sym_q;
  logic                out_end_q;
  logic                out_last_q;

  mem_req_t            mem_req;
  node_t               ent_a;
  node_t               ent_b;
  node_t               cur;
  logic [NodeIdxW-1:0] nxt;
  logic                in_fire;
  logic                cfg_fire;
  logic                out_free;
  logic                hit_leaf;
  logic                hit_end;
  logic                stall;
  logic                push;
  logic [SymW-1:0]     push_sym;
  logic                push_end;
  logic                push_last;

  htwd_node_mem #(
    .NODE_COUNT(NODE_COUNT)
  ) u_node_mem (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rd_a_o(ent_a),
    .rd_b_o(ent_b)
  );

  // a root write goes first and never lands on a walk in progress
  assign in_i.ready  = (state_q == ST_IDLE) && !cfg_i.valid;
  assign cfg_i.ready = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;

  assign hit_leaf = ent_a.leaf;
  assign hit_end  = ent_a.leaf && ent_a.is_end;
  // a new leaf needs the pending result moved out first
  assign stall    = (state_q == ST_WALK) && hit_leaf && pend_valid_q && !out_free;

  // node whose children the next bit picks from
  always_comb begin
    if ((state_q == ST_WALK) && hit_leaf && !hit_end) begin
      cur = ent_b;
    end else begin
      cur = ent_a;
    end
    nxt = byte_q[7] ? cur.right : cur.left;
  end

  always_comb begin
    mem_req.wr_en   = in_fire && (in_i.mode == MODE_WRITE);
    mem_req.wr_addr = in_i.node_index;
    mem_req.wr_data = '{symbol: in_i.leaf_symbol, is_end: in_i.end_flag,
                        leaf: in_i.leaf_flag, right: in_i.right_child,
                        left: in_i.left_child};
    mem_req.rd_b_addr = root_q;
    unique case (state_q)
      ST_IDLE:  mem_req.rd_a_addr = walk_q;
      ST_FETCH: mem_req.rd_a_addr = nxt;
      ST_WALK:  mem_req.rd_a_addr = stall ? rd_addr_q : nxt;
      default:  mem_req.rd_a_addr = rd_addr_q;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    root_d       = root_q;
    walk_d       = walk_q;
    finished_d   = finished_q;
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    pend_end_d   = pend_end_q;
    cnt_d        = cnt_q;
    byte_d       = byte_q;
    rd_addr_d    = rd_addr_q;
    push         = 1'b0;
    push_sym     = pend_sym_q;
    push_end     = pend_end_q;
    push_last    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_i.mode)
            MODE_RESTART: begin
              walk_d     = root_q;
              finished_d = 1'b0;
            end
            MODE_DECODE: begin
              if (!finished_q) begin
                byte_d  = in_i.data_byte;
                state_d = ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        rd_addr_d = nxt;
        byte_d    = {byte_q[6:0], 1'b0};
        cnt_d     = 3'd7;
        state_d   = ST_WALK;
      end
      ST_WALK: begin
        if (!stall) begin
          if (hit_leaf) begin
            push         = pend_valid_q;
            pend_valid_d = 1'b1;
            pend_sym_d   = hit_end ? '0 : ent_a.symbol;
            pend_end_d   = hit_end;
          end
          if (hit_end) begin
            finished_d = 1'b1;
          end
          walk_d = (hit_leaf && !hit_end) ? root_q : rd_addr_q;
          if ((cnt_q == 3'd0) || hit_end) begin
            state_d = (pend_valid_q || hit_leaf) ? ST_FLUSH : ST_IDLE;
          end else begin
            rd_addr_d = nxt;
            byte_d    = {byte_q[6:0], 1'b0};
            cnt_d     = cnt_q - 3'd1;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          push         = 1'b1;
          push_last    = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_fire) begin
      root_d     = cfg_i.root_node;
      walk_d     = cfg_i.root_node;
      finished_d = 1'b0;
    end
  end

  always_comb begin
    if (push) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      root_q       <= '0;
      walk_q       <= '0;
      finished_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
    end else begin
      state_q      <= state_d;
      root_q       <= root_d;
      walk_q       <= walk_d;
      finished_q   <= finished_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    rd_addr_q  <= rd_addr_d;
    pend_sym_q <= pend_sym_d;
    pend_end_q <= pend_end_d;
    if (push) begin
      out_sym_q  <= push_sym;
      out_end_q  <= push_end;
      out_last_q <= push_last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_symbol = out_sym_q;
  assign out_o.stream_end = out_end_q;
  assign out_o.last       = out_last_q;

  // the end marker always closes the results of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_end_q |-> out_last_q)
    else $error("end marker without last");

  // flushing always has a result to hand out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> pend_valid_q)
    else $error("flush with no pending result");

  // a decode after the end of stream starts no walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && finished_q && !cfg_fire |=> (state_q == ST_IDLE))
    else $error("walk started after end of stream");

  // a push never overwrites a result still waiting on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("result pushed into a stalled output register");

  // the node fetch is always followed by the bit walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |=> (state_q == ST_WALK) && (cnt_q == 3'd7))
    else $error("fetch not followed by walk");

endmodule

[rtl/core/htwd_node_mem.sv]
// ----------------------------------------------------------------------------
// htwd_node_mem
// Node table: one write port, two synchronous read ports with registered
// read data. Indexes beyond the table read as an all-zero entry.
// ----------------------------------------------------------------------------
module htwd_node_mem import htwd_pkg::*; #(
  parameter int unsigned NODE_COUNT = 1024
) (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output node_t    rd_a_o,
  output node_t    rd_b_o
);

  localparam int unsigned IdxW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  node_t mem_q [NODE_COUNT];
  node_t rd_a_q;
  node_t rd_b_q;
  logic  oob_a_q;
  logic  oob_b_q;
  logic  wr_ok;

  assign wr_ok = req_i.wr_en && (32'(req_i.wr_addr) < NODE_COUNT);

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[IdxW'(req_i.wr_addr)] <= req_i.wr_data;
    end
    rd_a_q  <= mem_q[IdxW'(req_i.rd_a_addr)];
    rd_b_q  <= mem_q[IdxW'(req_i.rd_b_addr)];
    oob_a_q <= (32'(req_i.rd_a_addr) >= NODE_COUNT);
    oob_b_q <= (32'(req_i.rd_b_addr) >= NODE_COUNT);
  end

  assign rd_a_o = oob_a_q ? node_t'('0) : rd_a_q;
  assign rd_b_o = oob_b_q ? node_t'('0) : rd_b_q;

endmodule
